@@ sv/ppba_pkg.sv @@
// Shared types and constants for the pointer position boxcar average.
// No dependencies; imported by every other file of the block.
`default_nettype none

package ppba_pkg;

  localparam int GX_W  = 10;  // raw gun x
  localparam int GY_W  = 9;   // raw gun y
  localparam int RC_W  = 12;  // recoil offset
  localparam int AX_W  = 11;  // averaged x
  localparam int AY_W  = 14;  // averaged y plus recoil
  localparam int MAP_W = 11;  // mapped screen coordinate

  localparam logic signed [MAP_W-1:0] X_OFFSET = 11'sd220;
  localparam logic signed [MAP_W-1:0] Y_OFFSET = 11'sd536;

  typedef logic signed [MAP_W-1:0] map_t;

  // control handed to every cell of the window
  typedef struct packed {
    logic en;    // a word is taken this cycle
    logic fill;  // window empty: load the new pair into every cell
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/ppba_cell.sv @@
// One window cell: holds a mapped (x, y) pair and hands it to its older neighbor.
// Depends on ppba_pkg.
`default_nettype none

module ppba_cell (
  input  wire logic              clk_i,
  input  wire ppba_pkg::cell_ctl_t ctl_i,
  input  wire ppba_pkg::map_t    fill_x_i,
  input  wire ppba_pkg::map_t    fill_y_i,
  input  wire ppba_pkg::map_t    next_x_i,
  input  wire ppba_pkg::map_t    next_y_i,
  output ppba_pkg::map_t         x_o,
  output ppba_pkg::map_t         y_o
);
  import ppba_pkg::*;

  map_t x_q, x_d;
  map_t y_q, y_d;

  always_comb begin
    x_d = ctl_i.fill ? fill_x_i : next_x_i;
    y_d = ctl_i.fill ? fill_y_i : next_y_i;
  end

  // payload only, contents are meaningless until the first fill
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

@@ sv/ppba_divc.sv @@
// Signed divide of a window sum by the window length, truncating toward zero.
// Reciprocal multiply on the magnitude, one register stage. Depends on ppba_pkg.
`default_nettype none

module ppba_divc #(
  parameter int WINDOW_LENGTH = 10,
  localparam int LW = $clog2(WINDOW_LENGTH),
  localparam int SW = ppba_pkg::MAP_W + LW
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [SW-1:0] sum_i,
  output ppba_pkg::map_t            quot_o
);
  import ppba_pkg::*;

  // ceil(2^SH / N) is exact for every magnitude below 2^SW
  localparam int SH = SW + LW;
  localparam int MW = SW + 2;
  localparam int PW = SW + MW;
  localparam longint RECIP = ((longint'(1) << SH) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic          neg;
  logic [SW-1:0] mag;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [MAP_W-1:0] qmag;

  always_comb begin
    neg = sum_i[SW-1];
    mag = neg ? SW'(-sum_i) : SW'(sum_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(mag) * PW'(RECIP_C);
      neg_q  <= neg;
    end
  end

  // mean magnitude is under 1024, so it fits the mapped width
  assign qmag   = prod_q[SH +: MAP_W];
  assign quot_o = neg_q ? -$signed(qmag) : $signed(qmag);

endmodule

`default_nettype wire

@@ sv/pointer_position_boxcar_average.sv @@
// Top level: maps gun positions, keeps the window in a row of cells, averages.
// Depends on ppba_pkg, ppba_cell, ppba_divc.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o | gun_x_i, gun_y_i, recoil_i
//   out     | output    | out_valid_o/out_stall_i | avg_x_o, avg_y_o
//
// One word per cycle unless a held result stalls the pipe; each accepted word
// passes the running sum, reciprocal product and output registers on its way
// to out_valid_o. The whole pipe advances together; in_stall_o rises only while
// a result sits on the output and out_stall_i is high. Reset clears the valid
// bits and the window-filled flag; the first word after reset fills every cell.
`default_nettype none

module pointer_position_boxcar_average #(
  parameter int WINDOW_LENGTH = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [ppba_pkg::GX_W-1:0]     gun_x_i,
  input  wire logic [ppba_pkg::GY_W-1:0]     gun_y_i,
  input  wire logic [ppba_pkg::RC_W-1:0]     recoil_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [ppba_pkg::AX_W-1:0] avg_x_o,
  output      logic signed [ppba_pkg::AY_W-1:0] avg_y_o
);
  import ppba_pkg::*;

  localparam int LW = $clog2(WINDOW_LENGTH);
  localparam int SW = MAP_W + LW;
  localparam logic signed [SW-1:0] LEN_S = SW'(WINDOW_LENGTH);

  logic advance, accept;
  logic filled_q;
  logic v1_q, v2_q, v3_q;
  logic [RC_W-1:0] rc1_q, rc2_q;

  map_t mx, my;
  map_t x_cell [WINDOW_LENGTH];
  map_t y_cell [WINDOW_LENGTH];
  cell_ctl_t ctl;

  logic signed [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  map_t qx, qy;
  logic signed [AX_W-1:0] avg_x_q;
  logic signed [AY_W-1:0] avg_y_q, avg_y_d;

  assign advance = !(v3_q && out_stall_i);
  assign accept  = in_valid_i && advance;

  // screen mapping: x = gx - 220, y = 536 - 2*gy
  assign mx = $signed({1'b0, gun_x_i}) - X_OFFSET;
  assign my = Y_OFFSET - $signed({1'b0, gun_y_i, 1'b0});

  assign ctl.en   = accept;
  assign ctl.fill = !filled_q;

  // cell 0 holds the oldest pair, the last cell takes the new one
  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    if (k == WINDOW_LENGTH - 1) begin : g_tail
      ppba_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .fill_x_i(mx),
        .fill_y_i(my),
        .next_x_i(mx),
        .next_y_i(my),
        .x_o     (x_cell[k]),
        .y_o     (y_cell[k])
      );
    end else begin : g_body
      ppba_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .fill_x_i(mx),
        .fill_y_i(my),
        .next_x_i(x_cell[k+1]),
        .next_y_i(y_cell[k+1]),
        .x_o     (x_cell[k]),
        .y_o     (y_cell[k])
      );
    end
  end

  // running sums: drop the oldest cell, add the new pair; the first word loads its pair times the window length
  always_comb begin
    if (filled_q) begin
      sx_d = sx_q - SW'(x_cell[0]) + SW'(mx);
      sy_d = sy_q - SW'(y_cell[0]) + SW'(my);
    end else begin
      sx_d = SW'(mx) * LEN_S;
      sy_d = SW'(my) * LEN_S;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (advance) begin
      rc1_q   <= recoil_i;
      rc2_q   <= rc1_q;
      avg_x_q <= qx;
      avg_y_q <= avg_y_d;
    end
  end

  ppba_divc #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_div_x (
    .clk_i (clk_i),
    .en_i  (advance),
    .sum_i (sx_q),
    .quot_o(qx)
  );

  ppba_divc #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_div_y (
    .clk_i (clk_i),
    .en_i  (advance),
    .sum_i (sy_q),
    .quot_o(qy)
  );

  assign avg_y_d = AY_W'(qy) + $signed(AY_W'(rc2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      if (accept) begin
        filled_q <= 1'b1;
      end
      if (advance) begin
        v1_q <= in_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  assign in_stall_o  = !advance;
  assign out_valid_o = v3_q;
  assign avg_x_o     = avg_x_q;
  assign avg_y_o     = avg_y_q;

endmodule

`default_nettype wire

@@ sv/ppba_checker.sv @@
// Port-level checks for pointer_position_boxcar_average, bound to the top level.
// Depends on ppba_pkg widths only.
`default_nettype none

module ppba_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [ppba_pkg::AX_W-1:0] avg_x_o,
  input wire logic signed [ppba_pkg::AY_W-1:0] avg_y_o
);
  import ppba_pkg::*;

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("in_stall_o without a stalled output word");

  // an accepted word reaches out_valid_o when the output drains behind it
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // means stay in the mapped screen range
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (avg_x_o >= -11'sd220 && avg_x_o <= 11'sd803))
    else $error("avg_x_o out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (avg_y_o >= -14'sd486 && avg_y_o <= 14'sd4631))
    else $error("avg_y_o out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(avg_x_o) && $stable(avg_y_o)))
    else $error("stalled output word changed");

endmodule

bind pointer_position_boxcar_average ppba_checker u_ppba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .avg_x_o    (avg_x_o),
  .avg_y_o    (avg_y_o)
);

`default_nettype wire
